// ===== design/crpw_pkg.sv =====
// ----------------------------------------------------------------------------
// crpw_pkg
// shared types and constants of the catmull-rom path walker
// ----------------------------------------------------------------------------
package crpw_pkg;

  localparam int MAX_POINTS  = 16;
  localparam int ADDR_W      = 4;
  localparam int MAX_STEPS   = 4095;
  localparam int COORD_WIDTH = 32;
  localparam int STEP_W      = 12;
  localparam int TFRAC       = 16;
  localparam int ACC_W       = 40;
  localparam int SQ_W        = 26;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;
  localparam int CTR_W       = 5;

  localparam logic [4:0] PATH_LEN_RESET = 5'd4;
  localparam logic [7:0] SPU_RESET      = 8'd15;

  localparam logic [CFG_IDX_W-1:0] REG_PATH_LEN       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_UNIT = 1'b1;

  localparam logic REQ_WRITE   = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  typedef struct packed {
    logic                     req_type;
    logic [ADDR_W-1:0]        point_index;
    logic signed [31:0]       point_x;
    logic signed [31:0]       point_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0]       pos_x;
    logic signed [31:0]       pos_z;
    logic [ADDR_W-1:0]        segment;
    logic [STEP_W-1:0]        step_in_segment;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MOD, ST_ADV, ST_NBR, ST_READ, ST_CA, ST_CB, ST_CC,
    ST_SQRT, ST_CFIN, ST_DIVI, ST_DIV, ST_COEF, ST_HORN, ST_EMIT
  } state_t;

  typedef enum logic [1:0] {PT_PREV, PT_CUR, PT_NEXT, PT_FAR} pt_sel_t;

  typedef enum logic [1:0] {H_INNER, H_MID, H_LAST} hstep_t;

  typedef struct packed {
    logic    start;
    logic    mod_sub;
    logic    adv;
    logic    nbr;
    pt_sel_t rd_sel;
    logic    cap_en;
    pt_sel_t cap_sel;
    logic    cnt_a;
    logic    cnt_b;
    logic    cnt_c;
    logic    sqrt_step;
    logic    cnt_fin;
    logic    div_init;
    logic    div_step;
    logic    coef;
    logic    horn;
    logic    axis;
    hstep_t  hstep;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    logic idx_ge_n;
    logic new_seg;
  } sts_t;

endpackage

// ===== design/catmull_rom_path_walker.sv =====
// ----------------------------------------------------------------------------
// catmull_rom_path_walker
// walks a closed catmull-rom spline through up to 16 stored 2-d points
// ----------------------------------------------------------------------------
// a write word (req_type 0) stores one control point and is taken only in
// idle. an advance word returns the next point on the loop: a modulo pass of
// one cycle per subtract when path_len shrank below the current index, four
// ram reads, on a new segment a 13-step bit-serial square root for the
// segment length, then a 16-step restoring divide for t and six passes
// through the one shared horner multiplier. the result waits in an output
// register, so the next word is taken while it is unread.
// configuration port: index 0 path_len, index 1 steps_per_unit, always ready.
// ----------------------------------------------------------------------------
module catmull_rom_path_walker (
  input  logic                                clk,
  input  logic                                rst_n,
  // input words
  input  logic                                in_valid,
  output logic                                in_ready,
  input  crpw_pkg::in_t                       in_data,
  // result words
  output logic                                out_valid,
  input  logic                                out_ready,
  output crpw_pkg::out_t                      out_data,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [crpw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [crpw_pkg::CFG_DATA_W-1:0]     cfg_data
);

  crpw_pkg::cmd_t cmd;
  crpw_pkg::sts_t sts;
  logic           in_wr;

  // registers are writable at any time
  assign cfg_ready = 1'b1;

  // sequencer
  crpw_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_data.req_type),
    .in_ready    (in_ready),
    .in_wr       (in_wr),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .sts         (sts)
  );

  // tables, length, divider and spline arithmetic
  crpw_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .in_wr     (in_wr),
    .cfg_wr    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

// ===== design/crpw_ram.sv =====
// ----------------------------------------------------------------------------
// crpw_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module crpw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/crpw_ctrl.sv =====
// ----------------------------------------------------------------------------
// crpw_ctrl
// sequencer of the path walker: handshakes and datapath commands
// ----------------------------------------------------------------------------
module crpw_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_req_type,
  output logic            in_ready,
  output logic            in_wr,
  output logic            out_valid,
  input  logic            out_ready,
  output crpw_pkg::cmd_t  cmd,
  input  crpw_pkg::sts_t  sts
);

  crpw_pkg::state_t           state_r, state_nxt;
  logic [crpw_pkg::CTR_W-1:0] ctr_r, ctr_nxt;
  logic                       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= crpw_pkg::ST_IDLE;
      ctr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ctr_r       <= ctr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ctr_nxt       = ctr_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    in_wr         = 1'b0;
    unique case (state_r)
      crpw_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_req_type == crpw_pkg::REQ_WRITE) begin
            in_wr = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = crpw_pkg::ST_MOD;
          end
        end
      end
      crpw_pkg::ST_MOD: begin
        if (sts.idx_ge_n) cmd.mod_sub = 1'b1;
        else state_nxt = crpw_pkg::ST_ADV;
      end
      crpw_pkg::ST_ADV: begin
        cmd.adv   = 1'b1;
        state_nxt = crpw_pkg::ST_NBR;
      end
      crpw_pkg::ST_NBR: begin
        cmd.nbr   = 1'b1;
        ctr_nxt   = '0;
        state_nxt = crpw_pkg::ST_READ;
      end
      crpw_pkg::ST_READ: begin
        cmd.rd_sel  = crpw_pkg::pt_sel_t'(ctr_r[1:0]);
        cmd.cap_en  = (ctr_r != '0);
        cmd.cap_sel = crpw_pkg::pt_sel_t'(ctr_r[1:0] - 2'd1);
        ctr_nxt     = ctr_r + 1'b1;
        if (ctr_r == crpw_pkg::CTR_W'(4)) begin
          state_nxt = sts.new_seg ? crpw_pkg::ST_CA : crpw_pkg::ST_DIVI;
        end
      end
      crpw_pkg::ST_CA: begin
        cmd.cnt_a = 1'b1;
        state_nxt = crpw_pkg::ST_CB;
      end
      crpw_pkg::ST_CB: begin
        cmd.cnt_b = 1'b1;
        state_nxt = crpw_pkg::ST_CC;
      end
      crpw_pkg::ST_CC: begin
        cmd.cnt_c = 1'b1;
        ctr_nxt   = '0;
        state_nxt = crpw_pkg::ST_SQRT;
      end
      crpw_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        ctr_nxt       = ctr_r + 1'b1;
        if (ctr_r == crpw_pkg::CTR_W'(crpw_pkg::SQ_W / 2 - 1)) begin
          state_nxt = crpw_pkg::ST_CFIN;
        end
      end
      crpw_pkg::ST_CFIN: begin
        cmd.cnt_fin = 1'b1;
        state_nxt   = crpw_pkg::ST_DIVI;
      end
      crpw_pkg::ST_DIVI: begin
        cmd.div_init = 1'b1;
        ctr_nxt      = '0;
        state_nxt    = crpw_pkg::ST_DIV;
      end
      crpw_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        ctr_nxt      = ctr_r + 1'b1;
        if (ctr_r == crpw_pkg::CTR_W'(crpw_pkg::TFRAC - 1)) begin
          state_nxt = crpw_pkg::ST_COEF;
        end
      end
      crpw_pkg::ST_COEF: begin
        cmd.coef  = 1'b1;
        ctr_nxt   = '0;
        state_nxt = crpw_pkg::ST_HORN;
      end
      crpw_pkg::ST_HORN: begin
        cmd.horn = 1'b1;
        cmd.axis = (ctr_r >= crpw_pkg::CTR_W'(3));
        case (ctr_r)
          crpw_pkg::CTR_W'(0), crpw_pkg::CTR_W'(3): cmd.hstep = crpw_pkg::H_INNER;
          crpw_pkg::CTR_W'(1), crpw_pkg::CTR_W'(4): cmd.hstep = crpw_pkg::H_MID;
          default:                                  cmd.hstep = crpw_pkg::H_LAST;
        endcase
        ctr_nxt = ctr_r + 1'b1;
        if (ctr_r == crpw_pkg::CTR_W'(5)) state_nxt = crpw_pkg::ST_EMIT;
      end
      crpw_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = crpw_pkg::ST_IDLE;
        end
      end
      default: state_nxt = crpw_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== design/crpw_dp.sv =====
// ----------------------------------------------------------------------------
// crpw_dp
// datapath: point tables, segment length, t divider and spline evaluation
// ----------------------------------------------------------------------------
module crpw_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  crpw_pkg::in_t                       in_data,
  input  logic                                in_wr,
  input  logic                                cfg_wr,
  input  logic [crpw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [crpw_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  crpw_pkg::cmd_t                      cmd,
  output crpw_pkg::sts_t                      sts,
  output crpw_pkg::out_t                      out_data
);

  localparam int AW  = crpw_pkg::ADDR_W;
  localparam int SW  = crpw_pkg::STEP_W;
  localparam int CW  = crpw_pkg::ACC_W;
  localparam int QW  = crpw_pkg::SQ_W;
  localparam int TW  = crpw_pkg::TFRAC;
  localparam logic [39:0] LEN_LIM = 40'(crpw_pkg::MAX_STEPS) << TW;

  // configuration and walk state
  logic [4:0]    path_len_r;
  logic [7:0]    spu_r;
  logic [AW-1:0] seg_idx_r;
  logic [SW-1:0] step_ctr_r;
  logic [SW-1:0] seg_steps_r;

  // per-item work registers
  logic [AW-1:0]        idx_r, prev_r, i3_r, i4_r;
  logic signed [31:0]   px_r [4];
  logic signed [31:0]   pz_r [4];
  logic [39:0]          ax_r, az_r;
  logic                 sat_r;
  logic [55:0]          sqx_r, sqz_r;
  logic [QW-1:0]        sq_v_r, sq_rt_r, sq_b_r;
  logic [SW:0]          dv_rem_r;
  logic [TW-1:0]        t_r;
  logic signed [CW-1:0] cx_r [3];
  logic signed [CW-1:0] cz_r [3];
  logic signed [CW-1:0] acc_r;
  logic signed [31:0]   pos_x_r, pos_z_r;
  crpw_pkg::out_t       out_r;

  logic [4:0]    n_len;
  logic [AW-1:0] raddr;
  logic [31:0]   rx, rz;

  always_comb begin
    if (path_len_r == 5'd0) n_len = 5'd1;
    else if (path_len_r > 5'(crpw_pkg::MAX_POINTS)) n_len = 5'(crpw_pkg::MAX_POINTS);
    else n_len = path_len_r;
  end

  assign sts.idx_ge_n = ({1'b0, idx_r} >= n_len);
  assign sts.new_seg  = (step_ctr_r == '0);

  always_comb begin
    unique case (cmd.rd_sel)
      crpw_pkg::PT_PREV: raddr = prev_r;
      crpw_pkg::PT_CUR:  raddr = idx_r;
      crpw_pkg::PT_NEXT: raddr = i3_r;
      crpw_pkg::PT_FAR:  raddr = i4_r;
      default:           raddr = idx_r;
    endcase
  end

  crpw_ram #(.WIDTH(32), .DEPTH(crpw_pkg::MAX_POINTS)) u_ram_x (
    .clk(clk), .we(in_wr), .waddr(in_data.point_index), .wdata(in_data.point_x),
    .raddr(raddr), .rdata(rx)
  );

  crpw_ram #(.WIDTH(32), .DEPTH(crpw_pkg::MAX_POINTS)) u_ram_z (
    .clk(clk), .we(in_wr), .waddr(in_data.point_index), .wdata(in_data.point_z),
    .raddr(raddr), .rdata(rz)
  );

  // neighbour indices
  logic [AW-1:0] idx_inc, i3_w, i4_w, prev_w;
  always_comb begin
    idx_inc = ({1'b0, idx_r} + 5'd1 == n_len) ? '0 : idx_r + 1'b1;
    i3_w    = idx_inc;
    i4_w    = ({1'b0, i3_w} + 5'd1 == n_len) ? '0 : i3_w + 1'b1;
    prev_w  = (idx_r == '0) ? AW'(n_len - 5'd1) : idx_r - 1'b1;
  end

  // segment length terms
  logic signed [32:0] dx, dz;
  logic [31:0]        adx, adz;
  logic [56:0]        sq_sum;
  logic [QW-1:0]      c_ceil, rb;
  logic [QW-1:0]      root_up;
  always_comb begin
    dx      = 33'(px_r[2]) - 33'(px_r[1]);
    dz      = 33'(pz_r[2]) - 33'(pz_r[1]);
    adx     = dx[32] ? 32'(-dx) : dx[31:0];
    adz     = dz[32] ? 32'(-dz) : dz[31:0];
    sq_sum  = {1'b0, sqx_r} + {1'b0, sqz_r};
    c_ceil  = QW'(sq_sum[56:32]) + QW'(sq_sum[31:0] != '0);
    rb      = sq_rt_r + sq_b_r;
    root_up = sq_rt_r + QW'(sq_v_r != '0);
  end

  // t divider
  logic [SW+1:0] dv_two;
  assign dv_two = {dv_rem_r, 1'b0};

  // horner step
  logic signed [CW-1:0]    h_op, h_add, h_res;
  logic signed [CW+TW:0]   h_prod;
  logic signed [CW-1:0]    h_half;
  logic signed [31:0]      h_pos;
  always_comb begin
    h_op  = (cmd.hstep == crpw_pkg::H_INNER) ? (cmd.axis ? cz_r[2] : cx_r[2]) : acc_r;
    case (cmd.hstep)
      crpw_pkg::H_INNER: h_add = cmd.axis ? cz_r[1] : cx_r[1];
      crpw_pkg::H_MID:   h_add = cmd.axis ? cz_r[0] : cx_r[0];
      default:           h_add = CW'(cmd.axis ? pz_r[1] : px_r[1]) <<< 1;
    endcase
    h_prod = h_op * $signed({1'b0, t_r});
    h_res  = h_add + h_prod[CW+TW-1:TW];
    h_half = (h_res + CW'(1)) >>> 1;
    if (h_half > CW'(32'sh7fffffff)) h_pos = 32'sh7fffffff;
    else if (h_half < -CW'(33'sh080000000)) h_pos = 32'sh80000000;
    else h_pos = h_half[31:0];
  end

  // coefficient terms, sign-extended to the accumulator width
  function automatic logic signed [CW-1:0] coef_c2(
    input logic signed [31:0] p1, p2, p3, p4);
    return (CW'(p1) <<< 1) - CW'(p2) * 5 + (CW'(p3) <<< 2) - CW'(p4);
  endfunction

  function automatic logic signed [CW-1:0] coef_c3(
    input logic signed [31:0] p1, p2, p3, p4);
    return -CW'(p1) + CW'(p2) * 3 - CW'(p3) * 3 + CW'(p4);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      path_len_r  <= crpw_pkg::PATH_LEN_RESET;
      spu_r       <= crpw_pkg::SPU_RESET;
      seg_idx_r   <= '0;
      step_ctr_r  <= '0;
      seg_steps_r <= SW'(1);
    end else begin
      if (cfg_wr) begin
        unique case (cfg_index)
          crpw_pkg::REG_PATH_LEN:       path_len_r <= cfg_data[4:0];
          crpw_pkg::REG_STEPS_PER_UNIT: spu_r      <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.cnt_fin) begin
        if (sat_r || root_up > QW'(crpw_pkg::MAX_STEPS)) seg_steps_r <= SW'(crpw_pkg::MAX_STEPS);
        else if (root_up == '0) seg_steps_r <= SW'(1);
        else seg_steps_r <= root_up[SW-1:0];
      end
      if (cmd.emit) begin
        seg_idx_r  <= idx_r;
        step_ctr_r <= (step_ctr_r + 1'b1 == seg_steps_r) ? '0 : step_ctr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) idx_r <= seg_idx_r;
    if (cmd.mod_sub) idx_r <= idx_r - n_len[AW-1:0];
    if (cmd.adv && sts.new_seg) idx_r <= idx_inc;
    if (cmd.nbr) begin
      prev_r <= prev_w;
      i3_r   <= i3_w;
      i4_r   <= i4_w;
    end
    if (cmd.cap_en) begin
      px_r[cmd.cap_sel] <= rx;
      pz_r[cmd.cap_sel] <= rz;
    end
    if (cmd.cnt_a) begin
      ax_r <= adx * spu_r;
      az_r <= adz * spu_r;
    end
    if (cmd.cnt_b) begin
      sat_r <= (ax_r > LEN_LIM) || (az_r > LEN_LIM);
      sqx_r <= ax_r[27:0] * ax_r[27:0];
      sqz_r <= az_r[27:0] * az_r[27:0];
    end
    if (cmd.cnt_c) begin
      sq_v_r  <= c_ceil;
      sq_rt_r <= '0;
      sq_b_r  <= QW'(1) << (QW - 2);
    end
    if (cmd.sqrt_step) begin
      if (sq_v_r >= rb) begin
        sq_v_r  <= sq_v_r - rb;
        sq_rt_r <= (sq_rt_r >> 1) + sq_b_r;
      end else begin
        sq_rt_r <= sq_rt_r >> 1;
      end
      sq_b_r <= sq_b_r >> 2;
    end
    if (cmd.div_init) begin
      dv_rem_r <= {1'b0, step_ctr_r};
      t_r      <= '0;
    end
    if (cmd.div_step) begin
      if (dv_two >= {2'b00, seg_steps_r}) begin
        dv_rem_r <= (SW+1)'(dv_two - {2'b00, seg_steps_r});
        t_r      <= {t_r[TW-2:0], 1'b1};
      end else begin
        dv_rem_r <= dv_two[SW:0];
        t_r      <= {t_r[TW-2:0], 1'b0};
      end
    end
    if (cmd.coef) begin
      cx_r[0] <= CW'(px_r[2]) - CW'(px_r[0]);
      cx_r[1] <= coef_c2(px_r[0], px_r[1], px_r[2], px_r[3]);
      cx_r[2] <= coef_c3(px_r[0], px_r[1], px_r[2], px_r[3]);
      cz_r[0] <= CW'(pz_r[2]) - CW'(pz_r[0]);
      cz_r[1] <= coef_c2(pz_r[0], pz_r[1], pz_r[2], pz_r[3]);
      cz_r[2] <= coef_c3(pz_r[0], pz_r[1], pz_r[2], pz_r[3]);
    end
    if (cmd.horn) begin
      acc_r <= h_res;
      if (cmd.hstep == crpw_pkg::H_LAST) begin
        if (cmd.axis) pos_z_r <= h_pos;
        else pos_x_r <= h_pos;
      end
    end
    if (cmd.emit) begin
      out_r.pos_x           <= pos_x_r;
      out_r.pos_z           <= pos_z_r;
      out_r.segment         <= idx_r;
      out_r.step_in_segment <= step_ctr_r;
    end
  end

  assign out_data = out_r;

endmodule
